FILE: sv/tlbl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbl_pkg
// Shared constants, types and controller/datapath handshake structs for the
// fully associative translation buffer with lru replacement.
// ----------------------------------------------------------------------------
package tlbl_pkg;

  localparam int TlbEntries = 16;
  localparam int PageBits   = 8;
  localparam int FrameBits  = 8;
  localparam int CountBits  = 32;
  localparam int IdxBits    = $clog2(TlbEntries);
  localparam int RankBits   = IdxBits;

  typedef logic [PageBits-1:0]  page_t;
  typedef logic [FrameBits-1:0] frame_t;
  typedef logic [CountBits-1:0] count_t;
  typedef logic [IdxBits-1:0]   idx_t;
  typedef logic [RankBits-1:0]  rank_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_FILL
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic lookup;
    logic scan;
    logic fill;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic need_scan;
    logic scan_last;
  } dp_status_t;

endpackage

FILE: sv/tlbl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbl_if
// Valid/ready channel interfaces: lookup requests in, translations out.
// ----------------------------------------------------------------------------
interface tlbl_req_if;
  import tlbl_pkg::*;

  logic   valid;
  logic   ready;
  page_t  vpage;
  frame_t table_frame;
  logic   table_present;
  logic   fault_replaced;

  modport source (
    output valid, vpage, table_frame, table_present, fault_replaced,
    input  ready
  );

  modport sink (
    input  valid, vpage, table_frame, table_present, fault_replaced,
    output ready
  );
endinterface

interface tlbl_rsp_if;
  import tlbl_pkg::*;

  logic   valid;
  logic   ready;
  frame_t pframe;
  logic   tlb_hit;
  logic   page_fault;
  count_t lookup_total;
  count_t hit_total;
  count_t fault_total;

  modport source (
    output valid, pframe, tlb_hit, page_fault, lookup_total, hit_total,
           fault_total,
    input  ready
  );

  modport sink (
    input  valid, pframe, tlb_hit, page_fault, lookup_total, hit_total,
           fault_total,
    output ready
  );
endinterface

FILE: sv/tlbl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbl_ctrl
// Sequencer for one lookup: tag match, optional frame invalidation scan,
// entry fill on a miss. Owns both channel handshakes.
// ----------------------------------------------------------------------------
module tlbl_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tlbl_pkg::dp_cmd_t    cmd_o,
  input  tlbl_pkg::dp_status_t status_i
);
  import tlbl_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (status_i.hit) begin
          state_d = ST_IDLE;
        end else if (status_i.need_scan) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_FILL;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_last) begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = !out_valid_q || out_ready_i;
        cmd_o.load_in = in_valid_i && in_ready_o;
      end
      ST_LOOKUP: cmd_o.lookup = 1'b1;
      ST_SCAN:   cmd_o.scan   = 1'b1;
      ST_FILL:   cmd_o.fill   = 1'b1;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == ST_LOOKUP) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result register must be free when a lookup writes it
  a_lookup_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOOKUP |-> !out_valid_q)
    else $error("lookup with result register still occupied");

  a_accept_to_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_LOOKUP)
    else $error("accepted transaction did not start a lookup");

  a_lookup_posts_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOOKUP |=> out_valid_q)
    else $error("lookup did not post a result");

endmodule

FILE: sv/tlbl_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbl_dpath
// Entry array with parallel tag match, recency ranks, frame invalidation
// scan, fill slot selection, counters and the result register.
// ----------------------------------------------------------------------------
module tlbl_dpath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tlbl_pkg::dp_cmd_t    cmd_i,
  output tlbl_pkg::dp_status_t status_o,
  input  tlbl_pkg::page_t      vpage_i,
  input  tlbl_pkg::frame_t     table_frame_i,
  input  logic                 table_present_i,
  input  logic                 fault_replaced_i,
  output tlbl_pkg::frame_t     pframe_o,
  output logic                 tlb_hit_o,
  output logic                 page_fault_o,
  output tlbl_pkg::count_t     lookup_total_o,
  output tlbl_pkg::count_t     hit_total_o,
  output tlbl_pkg::count_t     fault_total_o
);
  import tlbl_pkg::*;

  logic [TlbEntries-1:0] valid_q;
  page_t                 page_q  [TlbEntries];
  frame_t                frame_q [TlbEntries];
  rank_t                 rank_q  [TlbEntries];

  page_t  req_page_q;
  frame_t req_frame_q;
  logic   req_present_q;
  logic   req_replaced_q;
  idx_t   scan_idx_q;

  count_t lookup_cnt_q, hit_cnt_q, fault_cnt_q;
  frame_t res_frame_q;
  logic   res_hit_q, res_fault_q;

  logic [TlbEntries-1:0] hit_vec;
  logic                  hit;
  idx_t                  match_idx;
  rank_t                 match_rank;
  idx_t                  free_idx;
  logic                  any_free;
  idx_t                  lru_idx;
  idx_t                  slot_idx;
  logic                  drop_now;
  rank_t                 drop_rank;
  logic                  fault;
  count_t                lookup_cnt_d, hit_cnt_d, fault_cnt_d;

  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    lru_idx   = '0;
    for (int i = TlbEntries - 1; i >= 0; i--) begin
      hit_vec[i] = valid_q[i] && (page_q[i] == req_page_q);
      if (hit_vec[i]) begin
        match_idx = idx_t'(i);
      end
      if (!valid_q[i]) begin
        free_idx = idx_t'(i);
      end
      if (rank_q[i] == rank_t'(TlbEntries - 1)) begin
        lru_idx = idx_t'(i);
      end
    end
  end

  assign hit        = |hit_vec;
  assign any_free   = ~&valid_q;
  assign match_rank = rank_q[match_idx];
  assign slot_idx   = any_free ? free_idx : lru_idx;
  assign drop_now   = valid_q[scan_idx_q] && (frame_q[scan_idx_q] == req_frame_q);
  assign drop_rank  = rank_q[scan_idx_q];
  assign fault      = !hit && !req_present_q;

  assign lookup_cnt_d = lookup_cnt_q + count_t'(1);
  assign hit_cnt_d    = hit ? hit_cnt_q + count_t'(1) : hit_cnt_q;
  assign fault_cnt_d  = fault ? fault_cnt_q + count_t'(1) : fault_cnt_q;

  assign status_o.hit       = hit;
  assign status_o.need_scan = !req_present_q && req_replaced_q;
  assign status_o.scan_last = scan_idx_q == idx_t'(TlbEntries - 1);

  // control state: valid bits, ranks, counters, scan index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      lookup_cnt_q <= '0;
      hit_cnt_q    <= '0;
      fault_cnt_q  <= '0;
      scan_idx_q   <= '0;
      for (int i = 0; i < TlbEntries; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (cmd_i.load_in) begin
        scan_idx_q <= '0;
      end
      if (cmd_i.lookup) begin
        lookup_cnt_q <= lookup_cnt_d;
        hit_cnt_q    <= hit_cnt_d;
        fault_cnt_q  <= fault_cnt_d;
        if (hit) begin
          for (int i = 0; i < TlbEntries; i++) begin
            if (valid_q[i] && (rank_q[i] < match_rank)) begin
              rank_q[i] <= rank_q[i] + rank_t'(1);
            end
          end
          rank_q[match_idx] <= '0;
        end
      end
      if (cmd_i.scan) begin
        scan_idx_q <= scan_idx_q + idx_t'(1);
        if (drop_now) begin
          for (int i = 0; i < TlbEntries; i++) begin
            if (valid_q[i] && (rank_q[i] > drop_rank)) begin
              rank_q[i] <= rank_q[i] - rank_t'(1);
            end
          end
          valid_q[scan_idx_q] <= 1'b0;
          rank_q[scan_idx_q]  <= '0;
        end
      end
      if (cmd_i.fill) begin
        for (int i = 0; i < TlbEntries; i++) begin
          if (valid_q[i] && (idx_t'(i) != slot_idx)) begin
            rank_q[i] <= rank_q[i] + rank_t'(1);
          end
        end
        valid_q[slot_idx] <= 1'b1;
        rank_q[slot_idx]  <= '0;
      end
    end
  end

  // payload: request, tags, frames, result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      req_page_q     <= vpage_i;
      req_frame_q    <= table_frame_i;
      req_present_q  <= table_present_i;
      req_replaced_q <= fault_replaced_i;
    end
    if (cmd_i.lookup) begin
      res_frame_q <= hit ? frame_q[match_idx] : req_frame_q;
      res_hit_q   <= hit;
      res_fault_q <= fault;
    end
    if (cmd_i.fill) begin
      page_q[slot_idx]  <= req_page_q;
      frame_q[slot_idx] <= req_frame_q;
    end
  end

  assign pframe_o       = res_frame_q;
  assign tlb_hit_o      = res_hit_q;
  assign page_fault_o   = res_fault_q;
  assign lookup_total_o = lookup_cnt_q;
  assign hit_total_o    = hit_cnt_q;
  assign fault_total_o  = fault_cnt_q;

  // a page is never held twice
  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(hit_vec) <= 1)
    else $error("page tag matches more than one entry");

  a_fill_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fill |=> valid_q != '0)
    else $error("fill left no valid entry");

  a_hit_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.lookup && hit |=> hit_cnt_q == $past(hit_cnt_q) + count_t'(1))
    else $error("hit not counted");

endmodule

FILE: sv/tlb_lookup_lru.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_lookup_lru
// Fully associative translation buffer, lru replacement, lookup counters.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one lookup per transaction: page number plus the page
//   table's frame, residency and fault-replacement flag. rsp_o carries the
//   translated frame, hit and fault flags and the running totals.
//   A transaction is accepted on req_i while the block is idle and the
//   result register is empty or being emptied in the same cycle.
//   The request is loaded while idle; the lookup state writes the result
//   register, which is then offered on rsp_o. A hit returns to idle, a miss
//   runs the fill state, and a fault that replaced a page first runs the
//   invalidation scan that checks one entry per cycle for the reused frame.
//   Table update after a miss overlaps with a result waiting on rsp_o.
//   If the receiver stalls, the result holds and no new request is taken
//   until it is consumed.
//   Reset clears all valid bits, recency ranks and counters; no clearing
//   pass is needed, the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module tlb_lookup_lru (
  input  logic      clk_i,
  input  logic      rst_ni,
  tlbl_req_if.sink  req_i,
  tlbl_rsp_if.source rsp_o
);
  import tlbl_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  tlbl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  tlbl_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .vpage_i          (req_i.vpage),
    .table_frame_i    (req_i.table_frame),
    .table_present_i  (req_i.table_present),
    .fault_replaced_i (req_i.fault_replaced),
    .pframe_o         (rsp_o.pframe),
    .tlb_hit_o        (rsp_o.tlb_hit),
    .page_fault_o     (rsp_o.page_fault),
    .lookup_total_o   (rsp_o.lookup_total),
    .hit_total_o      (rsp_o.hit_total),
    .fault_total_o    (rsp_o.fault_total)
  );

endmodule

FILE: tb/sv/tb_tlb_lookup_lru.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tlb_lookup_lru
// Self-checking bench for the lru translation buffer. A driver feeds lookups
// from a queue, a shadow copy of the buffer predicts each translation and the
// running totals, and a monitor compares every returned transaction field by
// field. Directed lookups cover fill, hit, lru eviction and frame
// invalidation, then random lookups over drifting page and frame windows.
// Both sides stall at random except for one quiet stretch.
// ----------------------------------------------------------------------------
module tb_tlb_lookup_lru;
  import tlbl_pkg::*;

  localparam int RandLookups = 1576;
  localparam int StallLimit  = 2000;

  typedef struct packed {
    page_t  page;
    frame_t tframe;
    logic   present;
    logic   replaced;
  } lookup_t;

  typedef struct packed {
    frame_t frame;
    logic   hit;
    logic   fault;
    count_t lookups;
    count_t hits;
    count_t faults;
  } xlat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tlbl_req_if req ();
  tlbl_rsp_if rsp ();

  tlb_lookup_lru i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always #4 clk_i = ~clk_i;

  lookup_t lookup_q[$];
  xlat_t   xlat_q[$];
  int      err_cnt  = 0;
  int      sent_cnt = 0;
  logic    calm;

  // shadow buffer
  logic   lru_valid [TlbEntries];
  page_t  lru_page  [TlbEntries];
  frame_t lru_frame [TlbEntries];
  rank_t  lru_rank  [TlbEntries];
  count_t lookup_cnt;
  count_t hit_cnt;
  count_t fault_cnt;

  assign calm = (sent_cnt >= 700) && (sent_cnt < 1000);

  // entries more recent than limit age by one
  function automatic void age_ranks(int limit);
    for (int i = 0; i < TlbEntries; i++) begin
      if (lru_valid[i] && int'(lru_rank[i]) < limit) lru_rank[i]++;
    end
  endfunction

  function automatic void drop_entry(int e);
    rank_t r;
    r = lru_rank[e];
    lru_valid[e] = 1'b0;
    lru_rank[e]  = '0;
    for (int i = 0; i < TlbEntries; i++) begin
      if (lru_valid[i] && lru_rank[i] > r) lru_rank[i]--;
    end
  endfunction

  function automatic xlat_t translate(lookup_t lk);
    xlat_t r;
    int    match;
    int    slot;
    rank_t best;
    r     = '0;
    match = -1;
    slot  = -1;
    lookup_cnt++;
    for (int i = 0; i < TlbEntries; i++) begin
      if (match < 0 && lru_valid[i] && lru_page[i] == lk.page) match = i;
    end
    if (match >= 0) begin
      r.hit   = 1'b1;
      r.frame = lru_frame[match];
      hit_cnt++;
      age_ranks(int'(lru_rank[match]));
      lru_rank[match] = '0;
    end else begin
      if (!lk.present) begin
        r.fault = 1'b1;
        fault_cnt++;
        if (lk.replaced) begin
          for (int i = 0; i < TlbEntries; i++) begin
            if (lru_valid[i] && lru_frame[i] == lk.tframe) drop_entry(i);
          end
        end
      end
      r.frame = lk.tframe;
      for (int i = 0; i < TlbEntries; i++) begin
        if (slot < 0 && !lru_valid[i]) slot = i;
      end
      if (slot < 0) begin
        best = '0;
        slot = 0;
        for (int i = 0; i < TlbEntries; i++) begin
          if (lru_rank[i] > best) begin
            best = lru_rank[i];
            slot = i;
          end
        end
        drop_entry(slot);
      end
      age_ranks(TlbEntries);
      lru_valid[slot] = 1'b1;
      lru_page[slot]  = lk.page;
      lru_frame[slot] = lk.tframe;
      lru_rank[slot]  = '0;
    end
    r.lookups = lookup_cnt;
    r.hits    = hit_cnt;
    r.faults  = fault_cnt;
    return r;
  endfunction

  function automatic void queue_lookup(page_t p, frame_t f, logic pres, logic repl);
    lookup_t lk;
    lk.page     = p;
    lk.tframe   = f;
    lk.present  = pres;
    lk.replaced = repl;
    lookup_q.push_back(lk);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : driver
    lookup_t nxt;
    if (!rst_ni) begin
      req.valid          <= 1'b0;
      req.vpage          <= '0;
      req.table_frame    <= '0;
      req.table_present  <= 1'b0;
      req.fault_replaced <= 1'b0;
      for (int i = 0; i < TlbEntries; i++) begin
        lru_valid[i] = 1'b0;
        lru_page[i]  = '0;
        lru_frame[i] = '0;
        lru_rank[i]  = '0;
      end
      lookup_cnt = '0;
      hit_cnt    = '0;
      fault_cnt  = '0;
    end else begin
      if (req.valid && req.ready) begin
        xlat_q.push_back(translate({req.vpage, req.table_frame,
                                    req.table_present, req.fault_replaced}));
        sent_cnt++;
      end
      if (!req.valid || req.ready) begin
        if (lookup_q.size() > 0 && (calm || $urandom_range(0, 99) >= 33)) begin
          nxt = lookup_q.pop_front();
          req.valid          <= 1'b1;
          req.vpage          <= nxt.page;
          req.table_frame    <= nxt.tframe;
          req.table_present  <= nxt.present;
          req.fault_replaced <= nxt.replaced;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    xlat_t want;
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= calm || ($urandom_range(0, 99) >= 33);
      if (rsp.valid && rsp.ready) begin
        if (xlat_q.size() == 0) begin
          $display("%0t ns: unexpected transaction, expected none, actual frame %0h",
                   $time, rsp.pframe);
          err_cnt++;
        end else begin
          want = xlat_q.pop_front();
          check_field("pframe", 32'(want.frame), 32'(rsp.pframe));
          check_field("tlb_hit", 32'(want.hit), 32'(rsp.tlb_hit));
          check_field("page_fault", 32'(want.fault), 32'(rsp.page_fault));
          check_field("lookup_total", want.lookups, rsp.lookup_total);
          check_field("hit_total", want.hits, rsp.hit_total);
          check_field("fault_total", want.faults, rsp.fault_total);
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < StallLimit) begin
      @(posedge clk_i);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle = 0;
      else idle++;
    end
    $display("tb_tlb_lookup_lru: done, errors");
    $finish;
  end

  initial begin : stimulus
    page_t  pbase;
    frame_t fbase;
    page_t  p;
    frame_t f;
    rst_ni             = 1'b0;
    pbase              = '0;
    fbase              = '0;

    // fault fill, plain miss with replaced flag ignored, hit with junk table fields
    queue_lookup(8'h00, 8'h00, 1'b0, 1'b0);
    queue_lookup(8'hff, 8'hff, 1'b1, 1'b1);
    queue_lookup(8'h00, 8'haa, 1'b0, 1'b1);
    // fill the buffer
    for (int i = 0; i < 14; i++) queue_lookup(page_t'(8'h10 + i), frame_t'(8'h40 + i), 1'b1, 1'b0);
    // full: evict lru
    queue_lookup(8'h80, 8'h55, 1'b1, 1'b0);
    // fault reusing a mapped frame invalidates that entry
    queue_lookup(8'h81, 8'h41, 1'b0, 1'b1);
    queue_lookup(8'h11, 8'h41, 1'b1, 1'b0);
    // two entries on one frame, both invalidated
    queue_lookup(8'h90, 8'h77, 1'b1, 1'b0);
    queue_lookup(8'h91, 8'h77, 1'b1, 1'b0);
    queue_lookup(8'h92, 8'h77, 1'b0, 1'b1);
    queue_lookup(8'h90, 8'h12, 1'b1, 1'b0);

    for (int n = 0; n < RandLookups; n++) begin
      if (n % 200 == 0) begin
        pbase = page_t'($urandom);
        fbase = frame_t'($urandom);
      end
      if ($urandom_range(0, 7) == 0) p = page_t'($urandom);
      else p = pbase ^ page_t'($urandom_range(0, 23));
      if ($urandom_range(0, 7) == 0) f = frame_t'($urandom);
      else f = fbase ^ frame_t'($urandom_range(0, 15));
      queue_lookup(p, f, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (lookup_q.size() != 0 || req.valid || xlat_q.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("tb_tlb_lookup_lru: done, clean");
    end else begin
      $display("tb_tlb_lookup_lru: done, errors");
    end
    $finish;
  end

endmodule

FILE: tlb_lookup_lru.f
sv/tlbl_pkg.sv
sv/tlbl_if.sv
sv/tlbl_ctrl.sv
sv/tlbl_dpath.sv
sv/tlb_lookup_lru.sv
tb/sv/tb_tlb_lookup_lru.sv
